// File: hdl/rtq_pkg.sv
// Shared types, constants and helpers for the RS-485 transmit command queue.
// No dependencies; used by the channel interfaces and the top level.
`default_nettype none

package rtq_pkg;

  localparam int QUEUE_DEPTH = 4;
  localparam int MAX_PAYLOAD = 19;
  localparam int FILL_W      = $clog2(QUEUE_DEPTH + 1);
  localparam int CODE_W      = 8;
  localparam int COUNT_W     = 5;
  localparam int QCOUNT_W    = 3;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 8;

  localparam logic [7:0] FRAME_OVERHEAD = 8'd7;
  localparam logic [7:0] TICKS_MAX      = 8'hFF;

  typedef enum logic [1:0] {
    MODE_ENQUEUE = 2'd0,
    MODE_SCAN    = 2'd1,
    MODE_TICK    = 2'd2,
    MODE_TIMEOUT = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    ACT_READ_ID  = 3'd0,
    ACT_HELLO    = 3'd1,
    ACT_ASK      = 3'd2,
    ACT_SET_ADDR = 3'd3,
    ACT_PASS     = 3'd4,
    ACT_UNKNOWN  = 3'd5
  } action_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DEVICE_ADDRESS   = 3'd0,
    REG_TIMEOUT_LIMIT    = 3'd1,
    REG_CODE_READ_ID     = 3'd2,
    REG_CODE_HELLO       = 3'd3,
    REG_CODE_ASK         = 3'd4,
    REG_CODE_SET_ADDRESS = 3'd5,
    REG_CODE_PASSTHROUGH = 3'd6
  } cfg_reg_t;

  typedef struct packed {
    logic [1:0]        mode;
    logic [CODE_W-1:0] command_code;
    logic [7:0]        passthrough_total;
  } in_item_t;

  typedef struct packed {
    logic                issued;
    logic [CODE_W-1:0]   issued_code;
    logic [2:0]          action;
    logic [COUNT_W-1:0]  byte_count;
    logic [7:0]          addr_char_high;
    logic [7:0]          addr_char_low;
    logic                accepted;
    logic                busy_res;
    logic [QCOUNT_W-1:0] queue_count;
  } out_item_t;

  // Uppercase ASCII hex digit of a nibble
  function automatic logic [7:0] hex_char(input logic [3:0] v);
    logic [7:0] r;
    if (v < 4'd10) begin
      r = 8'h30 + {4'h0, v};
    end else begin
      r = 8'h37 + {4'h0, v};
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// File: hdl/rtq_if.sv
// Request and result channel interfaces (valid/ready with payload).
// Depends on rtq_pkg for the payload structs.
`default_nettype none

interface rtq_in_if;
  logic              valid;
  logic              ready;
  rtq_pkg::in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface rtq_out_if;
  logic               valid;
  logic               ready;
  rtq_pkg::out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// File: hdl/rs485_tx_command_queue.sv
// Top level of the RS-485 transmit command queue.
// Depends on rtq_pkg and the channel interfaces in rtq_if.sv.
//
// Usage:
//   in_ch   : requests (mode, command_code, passthrough_total), valid/ready.
//   out_ch  : one result per request, valid/ready, in request order.
//   cfg_*   : plain write port; cfg_we writes cfg_wdata to register cfg_index
//             (device address, timeout limit, five command codes). Index 7 is
//             ignored. Write only while no request is outstanding.
// A request taken at an edge has its result registered
// at that same edge and presented from the next cycle on.
// Throughput is one request per cycle while the receiver takes each result;
// the queue update, the four slot compares and the frame classification all
// sit between the request handshake and the result register.
// The result register doubles as the only buffer: while a result waits on a
// stalled receiver, a new request is taken only in the cycle the old result
// leaves, so nothing is lost or overwritten.
// Reset (rst_n low, synchronous) empties the queue, zeroes all slots, clears
// the busy flag and wait counter, drops any pending result and restores the
// register defaults.
`default_nettype none

module rs485_tx_command_queue (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  rtq_in_if.sink                                in_ch,
  rtq_out_if.source                             out_ch,
  input  wire logic                             cfg_we,
  input  wire logic [rtq_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [rtq_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

  // Configuration registers
  logic [7:0] device_address_r, timeout_limit_r;
  logic [7:0] code_read_id_r, code_hello_r, code_ask_r;
  logic [7:0] code_set_address_r, code_passthrough_r;

  // Queue state
  logic [rtq_pkg::CODE_W-1:0] slots_r   [rtq_pkg::QUEUE_DEPTH];
  logic [rtq_pkg::CODE_W-1:0] slots_nxt [rtq_pkg::QUEUE_DEPTH];
  logic [rtq_pkg::FILL_W-1:0] fill_r, fill_nxt;
  logic                       busy_r, busy_nxt;
  logic [7:0]                 wait_r, wait_nxt;

  // Result register
  logic                 out_valid_r;
  rtq_pkg::out_item_t   out_data_r, out_data_nxt;

  logic in_fire;
  logic dup_hit;
  logic is_pass;
  logic [7:0] len_raw;
  logic [rtq_pkg::COUNT_W-1:0] len_clip;
  logic [rtq_pkg::CODE_W-1:0] head;

  assign in_ch.ready  = !out_valid_r || out_ch.ready;
  assign in_fire      = in_ch.valid && in_ch.ready;
  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_data_r;

  assign head    = slots_r[0];
  assign is_pass = (in_ch.data.command_code == code_passthrough_r);

  always_comb begin
    dup_hit = 1'b0;
    for (int i = 0; i < rtq_pkg::QUEUE_DEPTH; i++) begin
      if (slots_r[i] == in_ch.data.command_code) begin
        dup_hit = 1'b1;
      end
    end
  end

  // Pass-through payload length, wraps mod 256 then clips
  assign len_raw  = in_ch.data.passthrough_total - rtq_pkg::FRAME_OVERHEAD;
  assign len_clip = (len_raw > 8'(rtq_pkg::MAX_PAYLOAD))
                    ? rtq_pkg::COUNT_W'(rtq_pkg::MAX_PAYLOAD)
                    : len_raw[rtq_pkg::COUNT_W-1:0];

  always_comb begin
    for (int i = 0; i < rtq_pkg::QUEUE_DEPTH; i++) begin
      slots_nxt[i] = slots_r[i];
    end
    fill_nxt     = fill_r;
    busy_nxt     = busy_r;
    wait_nxt     = wait_r;
    out_data_nxt = '0;

    unique case (rtq_pkg::mode_t'(in_ch.data.mode))
      rtq_pkg::MODE_ENQUEUE: begin
        if (fill_r < rtq_pkg::FILL_W'(rtq_pkg::QUEUE_DEPTH)) begin
          if (is_pass || !dup_hit) begin
            for (int i = 0; i < rtq_pkg::QUEUE_DEPTH; i++) begin
              if (fill_r == rtq_pkg::FILL_W'(i)) begin
                slots_nxt[i] = in_ch.data.command_code;
              end
            end
            fill_nxt              = fill_r + 1'b1;
            out_data_nxt.accepted = 1'b1;
          end
        end else if (is_pass) begin
          // full: pass-through replaces the tail
          slots_nxt[rtq_pkg::QUEUE_DEPTH-1] = in_ch.data.command_code;
          out_data_nxt.accepted             = 1'b1;
        end
      end
      rtq_pkg::MODE_SCAN: begin
        if (!busy_r && fill_r != '0) begin
          for (int i = 0; i < rtq_pkg::QUEUE_DEPTH - 1; i++) begin
            slots_nxt[i] = slots_r[i+1];
          end
          slots_nxt[rtq_pkg::QUEUE_DEPTH-1] = '0;
          fill_nxt                 = fill_r - 1'b1;
          out_data_nxt.issued      = 1'b1;
          out_data_nxt.issued_code = head;
          priority if (head == code_read_id_r) begin
            out_data_nxt.action     = rtq_pkg::ACT_READ_ID;
            out_data_nxt.byte_count = 5'd7;
            busy_nxt                = 1'b1;
          end else if (head == code_hello_r) begin
            out_data_nxt.action     = rtq_pkg::ACT_HELLO;
            out_data_nxt.byte_count = 5'd7;
            busy_nxt                = 1'b1;
          end else if (head == code_ask_r) begin
            out_data_nxt.action     = rtq_pkg::ACT_ASK;
            out_data_nxt.byte_count = 5'd7;
            busy_nxt                = 1'b1;
          end else if (head == code_set_address_r) begin
            out_data_nxt.action         = rtq_pkg::ACT_SET_ADDR;
            out_data_nxt.byte_count     = 5'd9;
            busy_nxt                    = 1'b1;
            out_data_nxt.addr_char_high = rtq_pkg::hex_char(device_address_r[7:4]);
            out_data_nxt.addr_char_low  = rtq_pkg::hex_char(device_address_r[3:0]);
          end else if (head == code_passthrough_r) begin
            out_data_nxt.action     = rtq_pkg::ACT_PASS;
            out_data_nxt.byte_count = len_clip + 5'd7;
          end else begin
            out_data_nxt.action     = rtq_pkg::ACT_UNKNOWN;
            out_data_nxt.byte_count = '0;
            busy_nxt                = 1'b0;
            wait_nxt                = '0;
          end
        end
      end
      rtq_pkg::MODE_TICK: begin
        if (wait_r != rtq_pkg::TICKS_MAX) begin
          wait_nxt = wait_r + 8'd1;
        end
      end
      rtq_pkg::MODE_TIMEOUT: begin
        if (busy_r && wait_r >= timeout_limit_r) begin
          busy_nxt = 1'b0;
          wait_nxt = '0;
        end
      end
      default: begin
      end
    endcase

    out_data_nxt.busy_res    = busy_nxt;
    out_data_nxt.queue_count = rtq_pkg::QCOUNT_W'(fill_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      device_address_r   <= 8'd0;
      timeout_limit_r    <= 8'd8;
      code_read_id_r     <= 8'd1;
      code_hello_r       <= 8'd2;
      code_ask_r         <= 8'd3;
      code_set_address_r <= 8'd4;
      code_passthrough_r <= 8'd5;
    end else if (cfg_we) begin
      unique case (cfg_index)
        rtq_pkg::REG_DEVICE_ADDRESS:   device_address_r   <= cfg_wdata;
        rtq_pkg::REG_TIMEOUT_LIMIT:    timeout_limit_r    <= cfg_wdata;
        rtq_pkg::REG_CODE_READ_ID:     code_read_id_r     <= cfg_wdata;
        rtq_pkg::REG_CODE_HELLO:       code_hello_r       <= cfg_wdata;
        rtq_pkg::REG_CODE_ASK:         code_ask_r         <= cfg_wdata;
        rtq_pkg::REG_CODE_SET_ADDRESS: code_set_address_r <= cfg_wdata;
        rtq_pkg::REG_CODE_PASSTHROUGH: code_passthrough_r <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < rtq_pkg::QUEUE_DEPTH; i++) begin
        slots_r[i] <= '0;
      end
      fill_r      <= '0;
      busy_r      <= 1'b0;
      wait_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_fire) begin
        for (int i = 0; i < rtq_pkg::QUEUE_DEPTH; i++) begin
          slots_r[i] <= slots_nxt[i];
        end
        fill_r      <= fill_nxt;
        busy_r      <= busy_nxt;
        wait_r      <= wait_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_data_r <= out_data_nxt;
    end
  end

  // Checks
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= rtq_pkg::FILL_W'(rtq_pkg::QUEUE_DEPTH))
    else $error("queue fill beyond depth");

  a_fire_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> out_valid_r)
    else $error("request taken without a result");

  a_no_pop_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_data_r.issued) |->
      (out_data_r.byte_count == '0 && out_data_r.issued_code == '0))
    else $error("result fields set without a pop");

  a_pop_needs_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && out_data_nxt.issued) |-> (!busy_r && fill_r != '0))
    else $error("pop while busy or empty");

endmodule

`default_nettype wire
